>>> src/iraf_pkg.sv
`default_nettype none
package iraf_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int NUM_TABLES  = 4;
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
    localparam int TOTAL_W     = 9;

    localparam logic [31:0] BASE_KEY = 32'd1;

    localparam logic [1:0] K_CLEAR = 2'd0;
    localparam logic [1:0] K_ADD   = 2'd1;
    localparam logic [1:0] K_QUERY = 2'd2;

    localparam int TBL_ALLOW  = 0;
    localparam int TBL_EXCEPT = 1;
    localparam int TBL_OFFICE = 2;
    localparam int TBL_DENY   = 3;

    typedef struct packed {
        logic cmp;
        logic clr;
        logic add;
    } t_tbl_ctl;

    typedef struct packed {
        logic              hit;
        logic              multi;
        logic              drop;
        logic [FILL_W-1:0] fill_nxt;
    } t_tbl_stat;

    typedef struct packed {
        logic cmp;
        logic clr;
        logic ovr;
        logic ins;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> src/iraf_cell.sv
`default_nettype none
module iraf_cell
    import iraf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_head,
    input  wire t_cell_ctl   i_ctl,
    input  wire logic [31:0] i_key,
    input  wire logic [31:0] i_end,
    input  wire logic [31:0] i_left_lo,
    input  wire logic [31:0] i_left_hi,
    input  wire logic        i_left_valid,
    input  wire logic        i_left_lt,
    input  wire logic        i_right_le,
    output logic      [31:0] o_lo,
    output logic      [31:0] o_hi,
    output logic             o_valid,
    output logic             o_lt,
    output logic             o_le,
    output logic             o_eq,
    output logic             o_hit
);

    logic [31:0] r_lo, n_lo;
    logic [31:0] r_hi, n_hi;
    logic        r_valid, n_valid;
    logic        r_lt, r_le, r_eq, r_ge;

    always_comb begin
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_valid = r_valid;
        if (i_ctl.clr) begin
            n_lo    = BASE_KEY;
            n_hi    = BASE_KEY;
            n_valid = i_head;
        end else if (i_ctl.ovr && r_eq) begin
            n_hi = i_end;
        end else if (i_ctl.ins && !r_lt) begin
            if (i_left_lt) begin
                n_lo    = i_key;
                n_hi    = i_end;
                n_valid = 1'b1;
            end else begin
                n_lo    = i_left_lo;
                n_hi    = i_left_hi;
                n_valid = i_left_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo    <= BASE_KEY;
            r_hi    <= BASE_KEY;
            r_valid <= i_head;
            r_lt    <= 1'b0;
            r_le    <= 1'b0;
            r_eq    <= 1'b0;
            r_ge    <= 1'b0;
        end else begin
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_valid <= n_valid;
            if (i_ctl.cmp) begin
                r_lt <= r_valid && (r_lo < i_key);
                r_le <= r_valid && (r_lo <= i_key);
                r_eq <= r_valid && (r_lo == i_key);
                r_ge <= r_hi >= i_key;
            end
        end
    end

    assign o_lo    = r_lo;
    assign o_hi    = r_hi;
    assign o_valid = r_valid;
    assign o_lt    = r_lt;
    assign o_le    = r_le;
    assign o_eq    = r_eq;
    // floor entry: last cell whose start is not above the key; hit only if its end is not below the key
    assign o_hit   = r_le && !i_right_le && r_ge;

endmodule
`default_nettype wire

>>> src/iraf_table.sv
`default_nettype none
module iraf_table
    import iraf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_tbl_ctl    i_ctl,
    input  wire logic [31:0] i_key,
    input  wire logic [31:0] i_end,
    output t_tbl_stat        o_stat
);

    logic [31:0]            lo    [TABLE_DEPTH];
    logic [31:0]            hi    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid;
    logic [TABLE_DEPTH-1:0] lt;
    logic [TABLE_DEPTH-1:0] le;
    logic [TABLE_DEPTH-1:0] eq;
    logic [TABLE_DEPTH-1:0] hitv;

    logic [FILL_W-1:0] r_fill, n_fill;
    logic              any_eq;
    logic              full;
    t_cell_ctl         cell_ctl;

    assign any_eq = |eq;
    assign full   = (r_fill == FILL_W'(TABLE_DEPTH));

    assign cell_ctl.cmp = i_ctl.cmp;
    assign cell_ctl.clr = i_ctl.clr;
    assign cell_ctl.ovr = i_ctl.add && any_eq;
    assign cell_ctl.ins = i_ctl.add && !any_eq && !full;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic [31:0] left_lo, left_hi;
            logic        left_valid, left_lt, right_le;
            if (g == 0) begin : g_first
                assign left_lo    = BASE_KEY;
                assign left_hi    = BASE_KEY;
                assign left_valid = 1'b0;
                assign left_lt    = 1'b1;
            end else begin : g_mid
                assign left_lo    = lo[g-1];
                assign left_hi    = hi[g-1];
                assign left_valid = valid[g-1];
                assign left_lt    = lt[g-1];
            end
            if (g == TABLE_DEPTH - 1) begin : g_last
                assign right_le = 1'b0;
            end else begin : g_inner
                assign right_le = le[g+1];
            end

            iraf_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_head       ((g == 0) ? 1'b1 : 1'b0),
                .i_ctl        (cell_ctl),
                .i_key        (i_key),
                .i_end        (i_end),
                .i_left_lo    (left_lo),
                .i_left_hi    (left_hi),
                .i_left_valid (left_valid),
                .i_left_lt    (left_lt),
                .i_right_le   (right_le),
                .o_lo         (lo[g]),
                .o_hi         (hi[g]),
                .o_valid      (valid[g]),
                .o_lt         (lt[g]),
                .o_le         (le[g]),
                .o_eq         (eq[g]),
                .o_hit        (hitv[g])
            );
        end
    endgenerate

    always_comb begin
        n_fill = r_fill;
        if (i_ctl.clr) begin
            n_fill = FILL_W'(1);
        end else if (cell_ctl.ins) begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= FILL_W'(1);
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_stat.hit      = |hitv;
    assign o_stat.multi    = r_fill > FILL_W'(1);
    assign o_stat.drop     = i_ctl.add && !any_eq && full;
    assign o_stat.fill_nxt = n_fill;

endmodule
`default_nettype wire

>>> src/ip_range_access_filter_core.sv
// Each request is registered on accept, compared in S_CMP, then updated in S_UPD into the result register.
// A new request is taken only in S_IDLE, once the last one is through; each request walks the cell chains once,
// compare flags registered in every cell in S_CMP, then insert/shift/lookup in S_UPD.
// Update stalls while the output register still holds an untaken result.
// Reset (synchronous, active low): each table holds only the base range [1,1].
`default_nettype none
module ip_range_access_filter_core
    import iraf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_kind,
    input  wire logic [1:0]           i_table_select,
    input  wire logic [31:0]          i_address,
    input  wire logic [31:0]          i_range_count,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_allowed,
    output logic                      o_office,
    output logic                      o_table_full,
    output logic [TOTAL_W-1:0]        o_entry_total
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state      r_state, n_state;
    logic [1:0]  r_kind;
    logic [1:0]  r_sel;
    logic [31:0] r_key;
    logic [31:0] r_end;

    logic              r_out_valid;
    logic              r_allowed, r_office, r_full;
    logic [TOTAL_W-1:0] r_total;

    logic      out_free;
    logic      go;
    logic      in_acc;
    logic [31:0] swapped;
    t_tbl_ctl  ctl  [NUM_TABLES];
    t_tbl_stat stat [NUM_TABLES];

    logic              ok, ok_pre, n_allowed, n_office, n_full;
    logic              qv;
    logic [TOTAL_W-1:0] n_total;

    assign swapped  = {i_address[7:0], i_address[15:8], i_address[23:16], i_address[31:24]};
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;
    assign go       = (r_state == S_UPD) && out_free;

    genvar t;
    generate
        for (t = 0; t < NUM_TABLES; t++) begin : g_tbl
            assign ctl[t].cmp = (r_state == S_CMP);
            assign ctl[t].clr = go && (r_kind == K_CLEAR);
            assign ctl[t].add = go && (r_kind == K_ADD) && (r_sel == 2'(t));

            iraf_table u_table (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl[t]),
                .i_key   (r_key),
                .i_end   (r_end),
                .o_stat  (stat[t])
            );
        end
    endgenerate

    always_comb begin
        qv     = r_key != 32'd0;
        ok_pre = !stat[TBL_ALLOW].multi || (qv && stat[TBL_ALLOW].hit);
        ok     = ok_pre;
        if (ok_pre && qv && stat[TBL_DENY].hit) begin
            ok = 1'b0;
        end
        if (ok_pre && stat[TBL_EXCEPT].multi && qv && stat[TBL_EXCEPT].hit) begin
            ok = 1'b1;
        end
        n_allowed = (r_kind == K_QUERY) && ok;
        n_office  = (r_kind == K_QUERY) && stat[TBL_OFFICE].multi && qv
                    && stat[TBL_OFFICE].hit;
        n_full    = stat[TBL_ALLOW].drop || stat[TBL_EXCEPT].drop
                  || stat[TBL_OFFICE].drop || stat[TBL_DENY].drop;
        n_total   = TOTAL_W'(stat[TBL_ALLOW].fill_nxt) + TOTAL_W'(stat[TBL_EXCEPT].fill_nxt)
                  + TOTAL_W'(stat[TBL_OFFICE].fill_nxt) + TOTAL_W'(stat[TBL_DENY].fill_nxt)
                  - TOTAL_W'(NUM_TABLES);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_kind;
            r_sel  <= i_table_select;
            r_key  <= swapped;
            r_end  <= swapped + (i_range_count - 32'd1);
        end
        if (go) begin
            r_allowed <= n_allowed;
            r_office  <= n_office;
            r_full    <= n_full;
            r_total   <= n_total;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_allowed     = r_allowed;
    assign o_office      = r_office;
    assign o_table_full  = r_full;
    assign o_entry_total = r_total;

endmodule
`default_nettype wire
